// ===== hdl/amad_pkg.sv =====
// Shared types and constants for the apogee moving average detector.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package amad_pkg;

	localparam int ALT_W    = 24;
	localparam int TIME_W   = 32;
	localparam int MARGIN_W = 24;

	// samples held in the moving-average window
	localparam int WINDOW = 5;

	// running sum wide enough for WINDOW full-scale samples
	localparam int SUM_W = ALT_W + $clog2(WINDOW);

	// exact divide by WINDOW for 0 <= x < 2**SUM_W:
	// floor(x / WINDOW) == (x * RECIP) >> RECIP_SHIFT
	localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW);
	localparam int RECIP_W     = SUM_W + 1;
	localparam int PROD_W      = SUM_W + RECIP_W;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

	localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(320);

	typedef struct packed {
		logic signed [ALT_W-1:0] altitude_sample;
		logic                    sample_valid;
		logic [TIME_W-1:0]       sample_time;
	} in_item_t;

	typedef struct packed {
		logic signed [ALT_W-1:0] window_mean;
		logic signed [ALT_W-1:0] peak_average;
		logic                    apogee_now;
		logic [TIME_W-1:0]       apogee_time;
	} out_item_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] window_sum;
		logic [TIME_W-1:0]       sample_time;
	} sum_item_t;

	typedef struct packed {
		logic signed [ALT_W-1:0] window_mean;
		logic [TIME_W-1:0]       sample_time;
	} avg_item_t;

endpackage

// ===== hdl/apogee_moving_average_detector_unit.sv =====
// Apogee detector top level: handshake, margin register and pipeline control.
// Depends on amad_pkg, amad_window, amad_divider and amad_peak.

// One item is accepted per clock while in_ready is high; each gives one result
// via the input register, running-sum stage, reciprocal-multiply divide and
// peak/compare result register. The rate is set by the window and running-sum
// registers, which update once per item as it leaves the input register; the
// stages hold independently, so bubbles close up while a result waits.
// An item with sample_valid low reuses the newest sample in the window. The
// apogee_margin register (cfg_wr_data) should be written only while idle.
module apogee_moving_average_detector_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  amad_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output amad_pkg::out_item_t           out_item,
	input  logic                          cfg_wr_en,
	input  logic [amad_pkg::MARGIN_W-1:0] cfg_wr_data
);

	logic                          v1_q, v2_q, v3_q, out_valid_q;
	logic                          rdy1, rdy2, rdy3, rdy_out;
	logic                          acc_in, adv2, adv3, adv_out;
	logic [amad_pkg::MARGIN_W-1:0] margin_q;
	amad_pkg::in_item_t            item_s1;
	amad_pkg::sum_item_t           sum_s2;
	amad_pkg::avg_item_t           avg_s3;

	assign rdy_out = !out_valid_q || out_ready;
	assign rdy3    = !v3_q || rdy_out;
	assign rdy2    = !v2_q || rdy3;
	assign rdy1    = !v1_q || rdy2;

	assign acc_in  = in_valid && rdy1;
	assign adv2    = v1_q && rdy2;
	assign adv3    = v2_q && rdy3;
	assign adv_out = v3_q && rdy_out;

	assign in_ready  = rdy1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			out_valid_q <= 1'b0;
			margin_q    <= amad_pkg::MARGIN_RESET;
		end else begin
			v1_q        <= acc_in || (v1_q && !adv2);
			v2_q        <= adv2 || (v2_q && !adv3);
			v3_q        <= adv3 || (v3_q && !adv_out);
			out_valid_q <= adv_out || (out_valid_q && !out_ready);
			if (cfg_wr_en) begin
				margin_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			item_s1 <= in_item;
		end
	end

	amad_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv2),
		.item_s1 (item_s1),
		.sum_s2  (sum_s2)
	);

	amad_divider u_divider (
		.clk    (clk),
		.en     (adv3),
		.sum_in (sum_s2),
		.avg_s3 (avg_s3)
	);

	amad_peak u_peak (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv_out),
		.avg_in   (avg_s3),
		.margin   (margin_q),
		.out_item (out_item)
	);

	// the peak is a running maximum, so it never sits below the average it shows
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_item.peak_average >= out_item.window_mean))
		else $error("peak below average in result");

	// input stalls only when every stage is full and the result is held
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v1_q && v2_q && v3_q && out_valid_q && !out_ready))
		else $error("input stalled with a free stage");

	// a new result only appears from a filled divide stage
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(v3_q))
		else $error("result without an item in flight");

endmodule

// ===== hdl/amad_window.sv =====
// Sample window shift line and running sum.
// Depends on amad_pkg.
module amad_window (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  amad_pkg::in_item_t  item_s1,
	output amad_pkg::sum_item_t sum_s2
);

	logic signed [amad_pkg::ALT_W-1:0] window_q [amad_pkg::WINDOW];
	logic signed [amad_pkg::SUM_W-1:0] sum_q;
	logic [amad_pkg::TIME_W-1:0]       time_s2;
	logic signed [amad_pkg::ALT_W-1:0] sample;
	logic signed [amad_pkg::SUM_W-1:0] sum_next;

	// a sample flagged unusable repeats the newest stored one
	assign sample = item_s1.sample_valid ? item_s1.altitude_sample : window_q[0];
	assign sum_next = sum_q + amad_pkg::SUM_W'(sample)
		- amad_pkg::SUM_W'(window_q[amad_pkg::WINDOW-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < amad_pkg::WINDOW; i++) begin
				window_q[i] <= '0;
			end
			sum_q <= '0;
		end else if (en) begin
			window_q[0] <= sample;
			for (int i = 1; i < amad_pkg::WINDOW; i++) begin
				window_q[i] <= window_q[i-1];
			end
			sum_q <= sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			time_s2 <= item_s1.sample_time;
		end
	end

	// the sum register itself is the stage output
	assign sum_s2.window_sum  = sum_q;
	assign sum_s2.sample_time = time_s2;

endmodule

// ===== hdl/amad_divider.sv =====
// Divide the window sum by WINDOW, truncating toward zero.
// Reciprocal multiply on the magnitude; depends on amad_pkg.
module amad_divider (
	input  logic                clk,
	input  logic                en,
	input  amad_pkg::sum_item_t sum_in,
	output amad_pkg::avg_item_t avg_s3
);

	logic                               neg;
	logic [amad_pkg::SUM_W-1:0]         mag;
	logic [amad_pkg::PROD_W-1:0]        prod;
	logic [amad_pkg::ALT_W-1:0]         quot;
	logic signed [amad_pkg::ALT_W-1:0]  quot_s;
	logic signed [amad_pkg::ALT_W-1:0]  avg;

	assign neg  = sum_in.window_sum[amad_pkg::SUM_W-1];
	assign mag  = neg ? $unsigned(-sum_in.window_sum) : $unsigned(sum_in.window_sum);
	assign prod = amad_pkg::PROD_W'(mag) * amad_pkg::PROD_W'(amad_pkg::RECIP);
	// quotient magnitude never exceeds the 24 bit range
	assign quot   = prod[amad_pkg::RECIP_SHIFT +: amad_pkg::ALT_W];
	assign quot_s = $signed(quot);
	assign avg    = neg ? -quot_s : quot_s;

	always_ff @(posedge clk) begin
		if (en) begin
			avg_s3.window_mean <= avg;
			avg_s3.sample_time <= sum_in.sample_time;
		end
	end

endmodule

// ===== hdl/amad_peak.sv =====
// Peak tracking, apogee compare, timestamp latch and result register.
// Depends on amad_pkg.
module amad_peak (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  amad_pkg::avg_item_t           avg_in,
	input  logic [amad_pkg::MARGIN_W-1:0] margin,
	output amad_pkg::out_item_t           out_item
);

	logic signed [amad_pkg::ALT_W-1:0] peak_q;
	logic [amad_pkg::TIME_W-1:0]       stamp_q;
	logic signed [amad_pkg::ALT_W-1:0] peak_next;
	logic signed [amad_pkg::ALT_W:0]   diff;
	logic                              flag;
	logic [amad_pkg::TIME_W-1:0]       stamp_next;

	assign peak_next = (avg_in.window_mean > peak_q) ? avg_in.window_mean : peak_q;
	// one bit wider: the drop never overflows and is never negative
	assign diff = (amad_pkg::ALT_W+1)'(peak_next)
		- (amad_pkg::ALT_W+1)'(avg_in.window_mean);
	assign flag       = $unsigned(diff) > (amad_pkg::ALT_W+1)'(margin);
	assign stamp_next = flag ? avg_in.sample_time : stamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q  <= '0;
			stamp_q <= '0;
		end else if (en) begin
			peak_q  <= peak_next;
			stamp_q <= stamp_next;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_item.window_mean  <= avg_in.window_mean;
			out_item.peak_average <= peak_next;
			out_item.apogee_now   <= flag;
			out_item.apogee_time  <= stamp_next;
		end
	end

endmodule

// ===== tb/tb.sv =====
// Testbench for apogee_moving_average_detector_unit: random and directed altitude items,
// checked item by item against an in-bench moving-average and apogee predictor.
// Depends on amad_pkg and the block's RTL only.

class apogee_ledger;
	logic signed [amad_pkg::ALT_W-1:0] window_q [amad_pkg::WINDOW];
	longint                            running_sum;
	logic signed [amad_pkg::ALT_W-1:0] peak_avg;
	logic [amad_pkg::TIME_W-1:0]       latched_ms;
	logic [amad_pkg::MARGIN_W-1:0]     margin;
	amad_pkg::out_item_t               pending_reports [$];
	int                                errors;
	int                                shown;
	int                                accepted;
	int                                checked;
	int                                flags_seen;

	function new();
		foreach (window_q[i]) window_q[i] = '0;
		running_sum = 0;
		peak_avg    = '0;
		latched_ms  = '0;
		margin      = amad_pkg::MARGIN_RESET;
		errors      = 0;
		shown       = 0;
		accepted    = 0;
		checked     = 0;
		flags_seen  = 0;
	endfunction

	// work out the report that one accepted sample item causes
	function void note_sample(amad_pkg::in_item_t it);
		longint              s;
		longint              avg;
		bit                  flag;
		amad_pkg::out_item_t r;
		if (it.sample_valid) begin
			s = longint'(it.altitude_sample);
		end else begin
			s = longint'(window_q[0]);
		end
		running_sum += s - longint'(window_q[amad_pkg::WINDOW-1]);
		for (int i = amad_pkg::WINDOW - 1; i > 0; i--) window_q[i] = window_q[i-1];
		window_q[0] = amad_pkg::ALT_W'(s);
		// signed longint divide truncates toward zero
		avg = running_sum / amad_pkg::WINDOW;
		if (avg > longint'(peak_avg)) peak_avg = amad_pkg::ALT_W'(avg);
		flag = (longint'(peak_avg) - avg) > longint'(margin);
		if (flag) latched_ms = it.sample_time;
		r.window_mean  = amad_pkg::ALT_W'(avg);
		r.peak_average = peak_avg;
		r.apogee_now   = flag;
		r.apogee_time  = latched_ms;
		pending_reports.push_back(r);
		accepted++;
	endfunction

	function void check_report(amad_pkg::out_item_t got);
		amad_pkg::out_item_t want;
		if (pending_reports.size() == 0) begin
			errors++;
			if (shown < 10) begin
				shown++;
				$display("unexpected report: avg %0d peak %0d flag %0b stamp %0h",
					got.window_mean, got.peak_average, got.apogee_now,
					got.apogee_time);
			end
			return;
		end
		want = pending_reports.pop_front();
		checked++;
		if (got.apogee_now === 1'b1) flags_seen++;
		if (got.window_mean !== want.window_mean ||
			got.peak_average !== want.peak_average ||
			got.apogee_now !== want.apogee_now ||
			got.apogee_time !== want.apogee_time) begin
			errors++;
			if (shown < 10) begin
				shown++;
				$display("report %0d mismatch (exp/got): avg %0d/%0d peak %0d/%0d",
					checked, want.window_mean, got.window_mean,
					want.peak_average, got.peak_average);
				$display("    flag %0b/%0b stamp %0h/%0h", want.apogee_now,
					got.apogee_now, want.apogee_time, got.apogee_time);
			end
		end
	endfunction
endclass

module tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	amad_pkg::in_item_t            in_item;
	logic                          out_valid;
	logic                          out_ready;
	amad_pkg::out_item_t           out_item;
	logic                          cfg_wr_en;
	logic [amad_pkg::MARGIN_W-1:0] cfg_wr_data;

	apogee_ledger ledger;
	int           send_idle_pct;
	int           recv_stall_pct;
	int           hold_request;
	int           cycles;
	int           margins_written;

	apogee_moving_average_detector_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[apogee_moving_average_detector_unit] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) ledger.check_report(out_item);
	end

	// receiver: random stalls, plus one long hold-off counted here on request
	initial begin : receiver
		int hold_left;
		bit hold_taken;
		hold_left  = 0;
		hold_taken = 1'b0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0 && !hold_taken) begin
				hold_left  = hold_request;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic amad_pkg::in_item_t mk_item(longint alt, bit ok,
		logic [amad_pkg::TIME_W-1:0] ms);
		amad_pkg::in_item_t it;
		it.altitude_sample = amad_pkg::ALT_W'(alt);
		it.sample_valid    = ok;
		it.sample_time     = ms;
		return it;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(amad_pkg::in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_ready !== 1'b1);
		ledger.note_sample(it);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (ledger.pending_reports.size() != 0) @(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_margin(logic [amad_pkg::MARGIN_W-1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en     <= 1'b0;
		ledger.margin  = v;
		margins_written++;
		@(negedge clk);
	endtask

	task automatic directed_items();
		// invalid item straight after reset repeats the zero window entry
		send_item(mk_item(24'h123456, 1'b0, 32'd0));
		// below-zero averages must not lift the peak from zero
		send_item(mk_item(-1000, 1'b1, 32'd10));
		send_item(mk_item(-1000, 1'b1, 32'd20));
		send_item(mk_item(-5000, 1'b1, 32'd30));
		send_item(mk_item(-5000, 1'b1, 32'd40));
		send_item(mk_item(0, 1'b0, 32'd50));
		send_item(mk_item(-1, 1'b1, 32'd60));
		// climb, hold and fall back past the margin
		send_item(mk_item(100, 1'b1, 32'd70));
		send_item(mk_item(2000, 1'b1, 32'd80));
		send_item(mk_item(8000, 1'b1, 32'd90));
		send_item(mk_item(16000, 1'b1, 32'd100));
		send_item(mk_item(16000, 1'b1, 32'd110));
		send_item(mk_item(-8388608, 1'b0, 32'd120));
		send_item(mk_item(4000, 1'b1, 32'd130));
		send_item(mk_item(0, 1'b1, 32'd140));
		send_item(mk_item(0, 1'b1, 32'd150));
		send_item(mk_item(-1, 1'b1, 32'hffff_ffff));
		// field extremes, one at a time
		send_item(mk_item(8388607, 1'b1, 32'hffff_ffff));
		send_item(mk_item(-8388608, 1'b1, 32'h8000_0000));
		send_item(mk_item(-8388608, 1'b0, 32'h7fff_ffff));
		send_item(mk_item(8388607, 1'b0, 32'h0000_0001));
		send_item(mk_item(1, 1'b1, 32'hffff_fffe));
	endtask

	// flight-like profiles with noise, dropouts and the odd fully random item
	task automatic random_items(int n_items);
		int                          sent;
		int                          len;
		int                          apex;
		longint                      base;
		longint                      rate_up;
		longint                      rate_down;
		longint                      alt;
		logic [amad_pkg::TIME_W-1:0] ms;
		amad_pkg::in_item_t          it;
		sent = 0;
		while (sent < n_items) begin
			len       = $urandom_range(6, 40);
			apex      = $urandom_range(2, len - 1);
			base      = longint'($urandom_range(0, 16777215)) - 8388608;
			rate_up   = longint'($urandom_range(1, 1 << $urandom_range(4, 20)));
			rate_down = longint'($urandom_range(1, 1 << $urandom_range(4, 20)));
			ms        = $urandom;
			for (int k = 0; k < len && sent < n_items; k++) begin
				ms += $urandom_range(1, 100);
				if ($urandom_range(99) < 15) begin
					it.altitude_sample = amad_pkg::ALT_W'($urandom);
					it.sample_valid    = 1'($urandom_range(1));
					it.sample_time     = $urandom;
				end else begin
					if (k <= apex) begin
						alt = base + rate_up * k;
					end else begin
						alt = base + rate_up * apex - rate_down * (k - apex);
					end
					alt += longint'($urandom_range(0, 64)) - 32;
					if (alt > 8388607) alt = 8388607;
					if (alt < -8388608) alt = -8388608;
					it = mk_item(alt, 1'b1, ms);
					// dropout: the altitude field is junk
					if ($urandom_range(99) < 8) begin
						it.sample_valid    = 1'b0;
						it.altitude_sample = amad_pkg::ALT_W'($urandom);
					end
				end
				send_item(it);
				sent++;
			end
		end
	endtask

	task automatic run_phase(int send_pct, int recv_pct, int n_items);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		random_items(n_items);
		wait_drained();
	endtask

	initial begin
		ledger          = new();
		margins_written = 0;
		hold_request    = 0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		in_item         = '0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct  = 8;
		recv_stall_pct = 8;
		directed_items();
		wait_drained();

		run_phase(0, 0, 320);
		set_margin('0);
		run_phase(57, 0, 320);
		set_margin('1);
		run_phase(0, 57, 320);
		set_margin(amad_pkg::MARGIN_W'($urandom_range(0, 16777215)));
		run_phase(8, 8, 320);
		set_margin(amad_pkg::MARGIN_W'(320));
		// long output hold-off while items keep coming, so the pipe backs up
		hold_request = HOLD_CYCLES;
		run_phase(0, 0, 320);
		set_margin(amad_pkg::MARGIN_W'($urandom_range(1000, 5000000)));
		run_phase(8, 8, 300);

		// full-scale averages at both ends, then a dropout
		set_margin(amad_pkg::MARGIN_W'($urandom_range(0, 4000000)));
		send_idle_pct  = 0;
		recv_stall_pct = 57;
		repeat (5) send_item(mk_item(8388607, 1'b1, $urandom));
		repeat (5) send_item(mk_item(-8388608, 1'b1, $urandom));
		send_item(mk_item(0, 1'b0, $urandom));
		wait_drained();
		repeat (20) @(negedge clk);

		ledger.errors += ledger.pending_reports.size();
		$display("covered %0d sample items and %0d reports, %0d with apogee flagged,",
			ledger.accepted, ledger.checked, ledger.flags_seen);
		$display("over %0d margin settings, four idling mixes and a long hold-off; %0d failures",
			margins_written, ledger.errors);
		if (ledger.errors == 0) begin
			$display("[apogee_moving_average_detector_unit] OK");
		end else begin
			$display("[apogee_moving_average_detector_unit] ERROR");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
hdl/amad_pkg.sv
hdl/amad_window.sv
hdl/amad_divider.sv
hdl/amad_peak.sv
hdl/apogee_moving_average_detector_unit.sv
tb/tb.sv
